// ----- rtl/core/arot_pkg.sv -----
// ----------------------------------------------------------------------------
// arot_pkg
// Shared types and codes of the address range offset table.
// ----------------------------------------------------------------------------
package arot_pkg;

    // Operation carried in the request sideband.
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Completion status returned with every response.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT_LEFT,
        S_EMIT_RIGHT,
        S_TAIL,
        S_DONE
    } t_state;

    // Completion report from the sequencer to the response register.
    typedef struct packed {
        logic    valid;
        t_status status;
        logic    found;
    } t_done;

endpackage

// ----- rtl/core/arot_mem.sv -----
// ----------------------------------------------------------------------------
// arot_mem
// Simple dual-port table bank: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arot_mem
    import arot_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 147
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/arot_ctrl.sv -----
// ----------------------------------------------------------------------------
// arot_ctrl
// Sequencer: for add and remove, streams the live bank through the trim logic
// into the spare bank, inserts the new range in order on add, and swaps banks on success; a lookup scans the live bank.
// ----------------------------------------------------------------------------
module arot_ctrl
    import arot_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_WIDTH    = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_mode                 i_mode,
    input  logic [ADDR_WIDTH-1:0] i_range_begin,
    input  logic [ADDR_WIDTH-1:0] i_range_end,
    input  logic [ADDR_WIDTH-1:0] i_static_offset,
    input  logic [2:0]            i_access_bits,
    input  logic [ADDR_WIDTH-1:0] i_probe_addr,
    input  logic                  i_out_free,
    output t_done                 o_done,
    output logic [ADDR_WIDTH-1:0] o_mapped_offset,
    output logic [2:0]            o_hit_access
);

    localparam int AW   = ADDR_WIDTH;
    localparam int EW   = 3 * AW + 3;
    localparam int XW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int WW   = $clog2(TABLE_ENTRIES + 3);
    localparam logic [CW-1:0] NCNT = CW'(TABLE_ENTRIES);
    localparam logic [WW-1:0] NWR  = WW'(TABLE_ENTRIES);

    // Entry layout, lowest bits first: begin, limit, offset, access.
    function automatic logic [EW-1:0] pack_ent(input logic [AW-1:0] b, input logic [AW-1:0] l,
                                              input logic [AW-1:0] o, input logic [2:0] a);
        pack_ent = {a, o, l, b};
    endfunction

    t_state          r_state, n_state;
    logic            r_bank;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_i;
    logic [WW-1:0]   r_w;
    t_mode           r_mode;
    logic [AW-1:0]   r_b, r_e, r_off, r_probe;
    logic [2:0]      r_acc;
    logic            r_ins, r_chg, r_empty, r_hit;
    logic [AW-1:0]   r_moff;
    logic [2:0]      r_hacc;
    logic [EW-1:0]   r_p0, r_p1;
    logic            r_p0v, r_p1v;

    logic [EW-1:0]   rd0, rd1, rdata;
    logic [AW-1:0]   cb, ce, co;
    logic [2:0]      ca;
    logic            we;
    logic [EW-1:0]   wdata;
    logic            wr_new;
    logic            overflow;
    logic            ov;

    assign rdata = r_bank ? rd1 : rd0;
    assign cb = rdata[AW-1:0];
    assign ce = rdata[2*AW-1:AW];
    assign co = rdata[3*AW-1:2*AW];
    assign ca = rdata[EW-1:3*AW];
    assign ov = (cb < r_e) && (ce > r_b);
    assign overflow = (r_w > NWR);

    // Next-state logic, write selection for the spare bank and completion report.
    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        wdata   = r_p1;
        wr_new  = 1'b0;
        o_done  = '{valid: 1'b0, status: STAT_OK, found: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_CLEAR) begin
                        n_state = S_DONE;
                    end else if (i_mode != MODE_LOOKUP && i_range_begin == i_range_end) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_i == r_count) begin
                    n_state = (r_mode == MODE_LOOKUP) ? S_DONE : S_TAIL;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_mode == MODE_LOOKUP) begin
                    n_state = (cb <= r_probe && r_probe < ce) ? S_DONE : S_READ;
                end else begin
                    n_state = S_EMIT_LEFT;
                end
            end
            S_EMIT_LEFT: begin
                we      = r_p0v;
                wdata   = r_p0;
                n_state = S_EMIT_RIGHT;
            end
            S_EMIT_RIGHT: begin
                if (!r_p1v) begin
                    n_state = S_READ;
                end else if (r_ins && r_b < r_p1[AW-1:0]) begin
                    we     = 1'b1;
                    wr_new = 1'b1;
                    wdata  = pack_ent(r_b, r_e, r_off, r_acc);
                end else begin
                    we      = 1'b1;
                    n_state = S_READ;
                end
            end
            S_TAIL: begin
                we      = r_ins;
                wr_new  = r_ins;
                wdata   = pack_ent(r_b, r_e, r_off, r_acc);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state      = S_IDLE;
                    o_done.valid = 1'b1;
                    if (r_mode == MODE_LOOKUP) begin
                        o_done.found = r_hit;
                    end else if (r_mode == MODE_CLEAR) begin
                        o_done.found = 1'b0;
                    end else if (r_empty) begin
                        o_done.status = STAT_EMPTY;
                    end else if (overflow) begin
                        o_done.status = STAT_FULL;
                    end else begin
                        o_done.found = r_chg;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_mapped_offset = r_moff;
    assign o_hit_access    = r_hacc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mode  <= i_mode;
                        r_b     <= (i_range_begin > i_range_end) ? i_range_end : i_range_begin;
                        r_e     <= (i_range_begin > i_range_end) ? i_range_begin : i_range_end;
                        r_off   <= i_static_offset;
                        r_acc   <= i_access_bits;
                        r_probe <= i_probe_addr;
                        r_i     <= '0;
                        r_w     <= '0;
                        r_ins   <= (i_mode == MODE_ADD);
                        r_chg   <= 1'b0;
                        r_hit   <= 1'b0;
                        r_moff  <= '0;
                        r_hacc  <= '0;
                        r_empty <= (i_mode != MODE_LOOKUP) && (i_mode != MODE_CLEAR)
                                   && (i_range_begin == i_range_end);
                    end
                end
                S_EVAL: begin
                    r_i <= r_i + 1'b1;
                    if (r_mode == MODE_LOOKUP) begin
                        if (cb <= r_probe && r_probe < ce) begin
                            r_hit  <= 1'b1;
                            r_moff <= co + (r_probe - cb);
                            r_hacc <= ca;
                        end
                    end else if (ov) begin
                        r_chg <= 1'b1;
                        r_p0  <= pack_ent(cb, r_b, co, ca);
                        r_p0v <= (cb < r_b);
                        r_p1  <= pack_ent(r_e, ce, co + (r_e - cb), ca);
                        r_p1v <= (r_e < ce);
                    end else begin
                        r_p0v <= 1'b0;
                        r_p1  <= rdata;
                        r_p1v <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        if (r_mode == MODE_CLEAR) begin
                            r_count <= '0;
                        end else if (r_mode != MODE_LOOKUP && !r_empty && !overflow) begin
                            r_bank  <= ~r_bank;
                            r_count <= r_w[CW-1:0];
                        end
                    end
                end
                default: ;
            endcase
            if (we) begin
                r_w <= r_w + 1'b1;
            end
            if (wr_new) begin
                r_ins <= 1'b0;
            end
        end
    end

    // Writes past the table size are only counted, never stored.
    logic            mem_we;
    logic [XW-1:0]   waddr, raddr;

    assign mem_we = we && (r_w < NWR);
    assign waddr  = r_w[XW-1:0];
    assign raddr  = (r_i < NCNT) ? r_i[XW-1:0] : '0;

    arot_mem #(.DEPTH(TABLE_ENTRIES), .WIDTH(EW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (mem_we && r_bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    arot_mem #(.DEPTH(TABLE_ENTRIES), .WIDTH(EW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (mem_we && !r_bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

endmodule

// ----- rtl/core/address_range_offset_table_unit.sv -----
// ----------------------------------------------------------------------------
// address_range_offset_table_unit
// Sorted table of non-overlapping address ranges with add, remove, lookup
// and clear requests.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Sideband (tuser)  Payload (tdata)
//  s_axis    in         mode              range_begin, range_end, static_offset,
//                                         access_bits, probe_addr
//  m_axis    out        -                 status, found, mapped_offset, hit_access
//
// An add or remove walks every stored range through the read, evaluate and
// emit states and then writes the tail; a lookup walks the ranges only until the hit. The pace is
// set by the single read port of the table bank, which yields one range at a
// time, and by the single write port, which takes one trimmed piece per
// cycle. A clear or an empty range answers without reading the table.
// Reset clears the range count and bank select; the table banks themselves
// hold no reset and are only read below the count.
// A new request is taken while the previous response still waits; the
// sequencer then holds its completion until the response register is free.
// ----------------------------------------------------------------------------
module address_range_offset_table_unit
    import arot_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_WIDTH    = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // range_begin, range_end, static_offset, access_bits, probe_addr, zero pad
    input  logic [((4*ADDR_WIDTH+3+7)/8)*8-1:0]   s_axis_tdata,
    // mode
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // status, found, mapped_offset, hit_access, zero pad
    output logic [((ADDR_WIDTH+6+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int AW  = ADDR_WIDTH;
    localparam int OTW = ((AW + 6 + 7) / 8) * 8;

    logic                 r_busy;
    logic                 r_ovalid;
    logic [AW+5:0]        r_odata;
    logic                 start;
    logic                 out_free;
    t_done                done;
    logic [AW-1:0]        moff;
    logic [2:0]           hacc;

    // Requests are taken whenever the sequencer is free.
    assign s_axis_tready = !r_busy;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
            end else if (done.valid) begin
                r_busy <= 1'b0;
            end
            if (done.valid) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Response register; unused fields are already zero from the sequencer.
    always_ff @(posedge i_clk) begin
        if (done.valid) begin
            r_odata <= {hacc, moff, done.found, done.status};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OTW'(r_odata);

    arot_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_WIDTH    (ADDR_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_mode          (t_mode'(s_axis_tuser)),
        .i_range_begin   (s_axis_tdata[AW-1:0]),
        .i_range_end     (s_axis_tdata[2*AW-1:AW]),
        .i_static_offset (s_axis_tdata[3*AW-1:2*AW]),
        .i_access_bits   (s_axis_tdata[3*AW+2:3*AW]),
        .i_probe_addr    (s_axis_tdata[4*AW+2:3*AW+3]),
        .i_out_free      (out_free),
        .o_done          (done),
        .o_mapped_offset (moff),
        .o_hit_access    (hacc)
    );

endmodule
